>>> hdl/assert_macros.svh
// Assertion macros used by the checker module.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OPR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define OPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/opr_pkg.sv
// Types, codes and sizes for the optimal page replacement block.
// No dependencies.
package opr_pkg;

    localparam int NUM_FRAMES    = 8;
    localparam int MAX_PROCESSES = 8;
    localparam int REF_DEPTH     = 64;
    localparam int PAGE_BITS     = 10;

    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int PID_W      = $clog2(MAX_PROCESSES);
    localparam int REF_IDX_W  = $clog2(REF_DEPTH);
    localparam int REF_ADDR_W = PID_W + REF_IDX_W;
    localparam int DIST_W     = $clog2(REF_DEPTH + 1);
    localparam int LIM_W      = 4;
    localparam int CNT_W      = 32;

    localparam logic [DIST_W-1:0] NEVER_AGAIN = DIST_W'(REF_DEPTH);
    localparam logic [LIM_W-1:0]  LIM_RESET   = LIM_W'(8);

    localparam logic [2:0] ACT_REQUEST = 3'd0;
    localparam logic [2:0] ACT_ADVANCE = 3'd1;
    localparam logic [2:0] ACT_APPEND  = 3'd2;
    localparam logic [2:0] ACT_NEWLIST = 3'd3;
    localparam logic [2:0] ACT_FREE    = 3'd4;
    localparam logic [2:0] ACT_CLEAR   = 3'd5;

    localparam logic [2:0] OUT_HIT     = 3'd0;
    localparam logic [2:0] OUT_FILL    = 3'd1;
    localparam logic [2:0] OUT_REPLACE = 3'd2;
    localparam logic [2:0] OUT_DONE    = 3'd3;
    localparam logic [2:0] OUT_FULL    = 3'd4;

    typedef struct packed {
        logic [2:0]           action;
        logic [PID_W-1:0]     process_id;
        logic [PAGE_BITS-1:0] page_number;
    } req_t;

    typedef struct packed {
        logic [2:0]           outcome;
        logic [FRAME_W-1:0]   frame_index;
        logic [PID_W-1:0]     victim_owner;
        logic [PAGE_BITS-1:0] victim_page;
        logic [CNT_W-1:0]     hit_total;
        logic [CNT_W-1:0]     fault_total;
        logic [CNT_W-1:0]     replacement_total;
        logic [LIM_W-1:0]     frames_used;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_init;
        logic scan_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic needs_scan;
        logic scan_last;
    } status_t;

endpackage

>>> hdl/opr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module opr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/opr_ctrl.sv
// Sequencer for request handling and the victim scan.
// Depends on opr_pkg.
module opr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  opr_pkg::status_t status,
    output opr_pkg::cmd_t    cmd,
    output logic             busy
);
    import opr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.needs_scan)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> hdl/opr_datapath.sv
// Frame table, reference lists, counters and the next-use scan.
// Depends on opr_pkg and opr_ram.
module opr_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [opr_pkg::LIM_W-1:0] cfg_wdata,
    input  opr_pkg::req_t             req,
    input  opr_pkg::cmd_t             cmd,
    output opr_pkg::status_t          status,
    output logic                      done,
    output opr_pkg::rsp_t             rsp
);
    import opr_pkg::*;

    req_t                 req_reg;
    logic [LIM_W-1:0]     cfg_reg;
    logic                 valid_reg [NUM_FRAMES];
    logic [PID_W-1:0]     owner_reg [NUM_FRAMES];
    logic [PAGE_BITS-1:0] fpage_reg [NUM_FRAMES];
    logic [DIST_W-1:0]    cnt_reg   [MAX_PROCESSES];
    logic [DIST_W-1:0]    pos_reg   [MAX_PROCESSES];
    logic [CNT_W-1:0]     hits_reg, faults_reg, repl_reg;
    logic [CNT_W-1:0]     hits_next, faults_next, repl_next;
    logic [LIM_W-1:0]     used_reg, used_next;
    logic [FRAME_W-1:0]   f_reg, victim_reg;
    logic [DIST_W-1:0]    j_reg, pj_reg, best_reg;
    logic                 init_reg, pv_reg;
    rsp_t                 rsp_reg, rsp_next;
    logic                 done_reg;

    logic [LIM_W-1:0]     lim;
    logic                 hit, free_found;
    logic [FRAME_W-1:0]   hit_idx, free_idx;
    logic [LIM_W-1:0]     freed_n;
    logic [PID_W-1:0]     cur_owner, sel_pid;
    logic [PAGE_BITS-1:0] cur_page, rd_data;
    logic [DIST_W-1:0]    s_pos, s_cnt, gap;
    logic                 match_now, issue, frame_end, take;
    logic                 ram_we;
    logic [REF_ADDR_W-1:0] ram_waddr, ram_raddr;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            lim = LIM_W'(1);
        end
        else if (cfg_reg > LIM_W'(NUM_FRAMES))
        begin
            lim = LIM_W'(NUM_FRAMES);
        end
        else
        begin
            lim = cfg_reg;
        end
    end

    always_comb
    begin
        hit        = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        freed_n    = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--)
        begin
            if (LIM_W'(i) < lim && valid_reg[i] && owner_reg[i] == req_reg.process_id
                && fpage_reg[i] == req_reg.page_number)
            begin
                hit     = 1'b1;
                hit_idx = FRAME_W'(i);
            end
            if (LIM_W'(i) < lim && !valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = FRAME_W'(i);
            end
            if (valid_reg[i] && owner_reg[i] == req_reg.process_id)
            begin
                freed_n = freed_n + LIM_W'(1);
            end
        end
    end

    assign status.needs_scan = (req_reg.action == ACT_REQUEST) && !hit && !free_found;

    assign cur_owner = owner_reg[f_reg];
    assign cur_page  = fpage_reg[f_reg];
    assign sel_pid   = cmd.scan_step ? cur_owner : req_reg.process_id;
    assign s_pos     = pos_reg[sel_pid];
    assign s_cnt     = cnt_reg[sel_pid];

    assign match_now = pv_reg && (rd_data == cur_page);
    assign issue     = !init_reg && (j_reg < s_cnt) && !match_now;
    assign frame_end = !init_reg && (match_now || (!issue && !pv_reg));
    assign gap       = match_now ? (pj_reg - s_pos) : NEVER_AGAIN;
    assign take      = (f_reg == '0) || (gap > best_reg);

    assign status.scan_last = cmd.scan_step && frame_end
                              && ({1'b0, f_reg} == (lim - LIM_W'(1)));

    assign ram_we    = cmd.exec && ((req_reg.action == ACT_APPEND
                       && s_cnt < DIST_W'(REF_DEPTH)) || req_reg.action == ACT_NEWLIST);
    assign ram_waddr = {req_reg.process_id,
                        (req_reg.action == ACT_NEWLIST) ? REF_IDX_W'(0)
                                                        : s_cnt[REF_IDX_W-1:0]};
    assign ram_raddr = {cur_owner, j_reg[REF_IDX_W-1:0]};

    opr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (MAX_PROCESSES * REF_DEPTH)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req_reg.page_number),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    always_comb
    begin
        hits_next   = hits_reg;
        faults_next = faults_reg;
        repl_next   = repl_reg;
        used_next   = used_reg;
        rsp_next    = '0;
        rsp_next.outcome = OUT_DONE;
        if (cmd.commit)
        begin
            faults_next           = faults_reg + CNT_W'(1);
            repl_next             = repl_reg + CNT_W'(1);
            rsp_next.outcome      = OUT_REPLACE;
            rsp_next.frame_index  = victim_reg;
            rsp_next.victim_owner = owner_reg[victim_reg];
            rsp_next.victim_page  = fpage_reg[victim_reg];
        end
        else
        begin
            case (req_reg.action)
                ACT_REQUEST:
                begin
                    if (hit)
                    begin
                        hits_next            = hits_reg + CNT_W'(1);
                        rsp_next.outcome     = OUT_HIT;
                        rsp_next.frame_index = hit_idx;
                    end
                    else
                    begin
                        faults_next          = faults_reg + CNT_W'(1);
                        used_next            = used_reg + LIM_W'(1);
                        rsp_next.outcome     = OUT_FILL;
                        rsp_next.frame_index = free_idx;
                    end
                end
                ACT_APPEND:
                begin
                    if (s_cnt >= DIST_W'(REF_DEPTH))
                    begin
                        rsp_next.outcome = OUT_FULL;
                    end
                end
                ACT_FREE:
                begin
                    used_next = used_reg - freed_n;
                end
                ACT_CLEAR:
                begin
                    hits_next   = '0;
                    faults_next = '0;
                    repl_next   = '0;
                    used_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
        rsp_next.hit_total         = hits_next;
        rsp_next.fault_total       = faults_next;
        rsp_next.replacement_total = repl_next;
        rsp_next.frames_used       = used_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec || cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
        if (cmd.load)
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg    <= LIM_RESET;
            done_reg   <= 1'b0;
            hits_reg   <= '0;
            faults_reg <= '0;
            repl_reg   <= '0;
            used_reg   <= '0;
            f_reg      <= '0;
            victim_reg <= '0;
            j_reg      <= '0;
            pj_reg     <= '0;
            best_reg   <= '0;
            init_reg   <= 1'b0;
            pv_reg     <= 1'b0;
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                valid_reg[i] <= 1'b0;
                owner_reg[i] <= '0;
                fpage_reg[i] <= '0;
            end
            for (int p = 0; p < MAX_PROCESSES; p++)
            begin
                cnt_reg[p] <= '0;
                pos_reg[p] <= '0;
            end
        end
        else
        begin
            done_reg <= cmd.exec || cmd.commit;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (cmd.exec || cmd.commit)
            begin
                hits_reg   <= hits_next;
                faults_reg <= faults_next;
                repl_reg   <= repl_next;
                used_reg   <= used_next;
            end
            if (cmd.commit)
            begin
                owner_reg[victim_reg] <= req_reg.process_id;
                fpage_reg[victim_reg] <= req_reg.page_number;
            end
            if (cmd.exec)
            begin
                case (req_reg.action)
                    ACT_REQUEST:
                    begin
                        if (!hit)
                        begin
                            valid_reg[free_idx] <= 1'b1;
                            owner_reg[free_idx] <= req_reg.process_id;
                            fpage_reg[free_idx] <= req_reg.page_number;
                        end
                    end
                    ACT_ADVANCE:
                    begin
                        if (s_pos < s_cnt)
                        begin
                            pos_reg[req_reg.process_id] <= s_pos + DIST_W'(1);
                        end
                    end
                    ACT_APPEND:
                    begin
                        if (s_cnt < DIST_W'(REF_DEPTH))
                        begin
                            cnt_reg[req_reg.process_id] <= s_cnt + DIST_W'(1);
                        end
                    end
                    ACT_NEWLIST:
                    begin
                        cnt_reg[req_reg.process_id] <= DIST_W'(1);
                        pos_reg[req_reg.process_id] <= '0;
                    end
                    ACT_FREE:
                    begin
                        for (int i = 0; i < NUM_FRAMES; i++)
                        begin
                            if (valid_reg[i] && owner_reg[i] == req_reg.process_id)
                            begin
                                valid_reg[i] <= 1'b0;
                                owner_reg[i] <= '0;
                                fpage_reg[i] <= '0;
                            end
                        end
                        cnt_reg[req_reg.process_id] <= '0;
                        pos_reg[req_reg.process_id] <= '0;
                    end
                    ACT_CLEAR:
                    begin
                        for (int i = 0; i < NUM_FRAMES; i++)
                        begin
                            valid_reg[i] <= 1'b0;
                            owner_reg[i] <= '0;
                            fpage_reg[i] <= '0;
                        end
                        for (int p = 0; p < MAX_PROCESSES; p++)
                        begin
                            cnt_reg[p] <= '0;
                            pos_reg[p] <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.scan_init)
            begin
                f_reg    <= '0;
                init_reg <= 1'b1;
                pv_reg   <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (init_reg)
                begin
                    j_reg    <= s_pos;
                    init_reg <= 1'b0;
                    pv_reg   <= 1'b0;
                end
                else if (frame_end)
                begin
                    if (take)
                    begin
                        best_reg   <= gap;
                        victim_reg <= f_reg;
                    end
                    f_reg    <= f_reg + FRAME_W'(1);
                    init_reg <= 1'b1;
                    pv_reg   <= 1'b0;
                end
                else
                begin
                    pv_reg <= issue;
                    pj_reg <= j_reg;
                    if (issue)
                    begin
                        j_reg <= j_reg + DIST_W'(1);
                    end
                end
            end
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> hdl/optimal_page_replacement.sv
// Hits, fills, list actions: request registered, run in S_EXEC, done registered.
// Replacement: S_EXEC starts the scan, S_SCAN reads each managed frame's list entries
// through the one list RAM read port, S_COMMIT writes the victim, done is registered.
// One request at a time; busy stays high until done. Results cannot be stalled.
// Reset clears frames, lists, counters; the frame limit (cfg_reg) resets to 8. No clearing pass.
module optimal_page_replacement (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [opr_pkg::LIM_W-1:0] cfg_wdata,
    input  logic                      start,
    input  opr_pkg::req_t             req,
    output logic                      busy,
    output logic                      done,
    output opr_pkg::rsp_t             rsp
);
    import opr_pkg::*;

    cmd_t    cmd;
    status_t status;

    opr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    opr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .done      (done),
        .rsp       (rsp)
    );

endmodule

>>> hdl/opr_checker.sv
// Port-level checks for optimal_page_replacement, bound to the top level.
// Depends on opr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module opr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input opr_pkg::rsp_t rsp
);
    import opr_pkg::*;

    `OPR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `OPR_ASSERT_NOW(a_done_after_busy, done, $past(busy))
    `OPR_ASSERT_NEXT(a_done_single, done, !done)
    `OPR_ASSERT_NOW(a_frame_used, done && rsp.outcome < OUT_DONE, rsp.frames_used != '0)

endmodule

bind optimal_page_replacement opr_checker u_opr_checker (.*);
